// File: hw/rtl/gbt_pkg.sv
// gbt_pkg: shared types, codes and helpers of the graph traversal block
// no dependencies; imported by every module of the block
package gbt_pkg;

   localparam int VERTEX_W   = 6;
   localparam int FUNC_W     = 2;
   localparam int COUNT_W    = 7;
   localparam int ROW_MAX    = 64;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;
   localparam logic [CSR_ADDR_W-3:0] REG_VERTEX_COUNT = '0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_EDGE  = 2'd1,
      FUNC_DFS   = 2'd2,
      FUNC_BFS   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE,
      ST_DFS_SCAN,
      ST_DFS_POP,
      ST_BFS_DEQ,
      ST_BFS_ROW,
      ST_BFS_SCAN
   } state_type;

   // adjacency memory control
   typedef struct packed {
      logic                clear;
      logic                wr_en;
      logic [VERTEX_W-1:0] wr_row;
      logic [VERTEX_W-1:0] wr_col;
      logic                rd_en;
      logic [VERTEX_W-1:0] rd_row;
   } adj_cmd_type;

   // stack / queue memory control
   typedef struct packed {
      logic                wr_en;
      logic [VERTEX_W-1:0] wr_addr;
      logic [VERTEX_W-1:0] wr_data;
      logic                rd_en;
      logic [VERTEX_W-1:0] rd_addr;
   } ord_cmd_type;

   // binary index of a one-hot word
   function automatic logic [VERTEX_W-1:0] onehot_index(input logic [ROW_MAX-1:0] oh);
      logic [VERTEX_W-1:0] idx;
      idx = '0;
      for (int j = 0; j < ROW_MAX; j++) begin
         if (oh[j]) begin
            idx = idx | VERTEX_W'(j);
         end
      end
      return idx;
   endfunction

endpackage

// File: hw/rtl/gbt_adj_mem.sv
// gbt_adj_mem: adjacency bit matrix, one row per vertex, bit-write port
// and registered read port; per-row valid bits give the cleared state
// depends on gbt_pkg
module gbt_adj_mem #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gbt_pkg::adj_cmd_type    cmd,
   output logic [MAX_VERTICES-1:0] row
);
   import gbt_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);

   logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [MAX_VERTICES-1:0] rd_data_ff;
   logic                    rd_ok_ff;
   logic [VW-1:0]           wr_idx;
   logic [VW-1:0]           wr_bit;
   logic [VW-1:0]           rd_idx;

   assign wr_idx = cmd.wr_row[VW-1:0];
   assign wr_bit = cmd.wr_col[VW-1:0];
   assign rd_idx = cmd.rd_row[VW-1:0];

   // a row not yet valid is written whole, so stale bits vanish
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         if (row_valid_ff[wr_idx]) begin
            mem[wr_idx][wr_bit] <= 1'b1;
         end else begin
            mem[wr_idx] <= MAX_VERTICES'(1) << wr_bit;
         end
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_idx];
         rd_ok_ff   <= row_valid_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         row_valid_ff <= '0;
      end else if (cmd.wr_en) begin
         row_valid_ff[wr_idx] <= 1'b1;
      end
   end

   assign row = rd_ok_ff ? rd_data_ff : '0;

endmodule

// File: hw/rtl/gbt_order_mem.sv
// gbt_order_mem: vertex store used as the depth-first stack or the
// breadth-first queue; one write and one registered read per cycle
// depends on gbt_pkg
module gbt_order_mem #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                          clock,
   input  gbt_pkg::ord_cmd_type          cmd,
   output logic [gbt_pkg::VERTEX_W-1:0]  rdata
);
   import gbt_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);

   logic [VERTEX_W-1:0] mem [MAX_VERTICES];
   logic [VERTEX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr[VW-1:0]] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[cmd.rd_addr[VW-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/gbt_ctrl.sv
// gbt_ctrl: command decode, traversal sequencer, visited marks and the
// one-deep result hold that lets the final vertex be flagged
// depends on gbt_pkg; drives gbt_adj_mem and gbt_order_mem
module gbt_ctrl #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gbt_pkg::FUNC_W-1:0]    req_func,
   input  logic [gbt_pkg::VERTEX_W-1:0]  req_from_vertex,
   input  logic [gbt_pkg::VERTEX_W-1:0]  req_to_vertex,
   input  logic [gbt_pkg::COUNT_W-1:0]   vertex_count,
   output gbt_pkg::adj_cmd_type          adj_cmd,
   input  logic [MAX_VERTICES-1:0]       adj_row,
   output gbt_pkg::ord_cmd_type          ord_cmd,
   input  logic [gbt_pkg::VERTEX_W-1:0]  ord_rdata,
   output logic                          rsp_valid,
   output logic [gbt_pkg::VERTEX_W-1:0]  rsp_vertex,
   output logic                          rsp_last,
   output logic                          rsp_bad_start
);
   import gbt_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);

   state_type               state_ff, state_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [VERTEX_W-1:0]     pend_ff, pend_in;
   logic [CW-1:0]           depth_ff, depth_in;
   logic [CW-1:0]           head_ff, head_in;
   logic [VERTEX_W-1:0]     edge_row_ff, edge_row_in;
   logic [VERTEX_W-1:0]     edge_col_ff, edge_col_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0]     rsp_vertex_ff, rsp_vertex_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_bad_ff, rsp_bad_in;

   logic [COUNT_W-1:0]      n_use;
   logic [MAX_VERTICES-1:0] n_mask;
   logic                    accept;
   logic                    start_ok;
   logic                    edge_ok;
   logic [MAX_VERTICES-1:0] cand;
   logic [MAX_VERTICES-1:0] cand_low;
   logic                    cand_any;
   logic [VERTEX_W-1:0]     next_v;
   func_type                func;

   assign func     = func_type'(req_func);
   assign n_use    = (vertex_count > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                             : vertex_count;
   assign accept   = start && (state_ff == ST_IDLE);
   assign start_ok = COUNT_W'(req_from_vertex) < n_use;
   assign edge_ok  = start_ok && (COUNT_W'(req_to_vertex) < n_use);

   always_comb begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
         n_mask[j] = COUNT_W'(j) < n_use;
      end
   end

   // lowest unvisited neighbour of the row on the read port
   assign cand     = adj_row & ~visited_ff & n_mask;
   assign cand_any = |cand;
   assign cand_low = cand & (~cand + MAX_VERTICES'(1));
   assign next_v   = onehot_index(ROW_MAX'(cand_low));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func) inside
                  FUNC_CLEAR: state_in = ST_IDLE;
                  FUNC_EDGE:  state_in = edge_ok ? ST_EDGE : ST_IDLE;
                  FUNC_DFS:   state_in = start_ok ? ST_DFS_SCAN : ST_IDLE;
                  FUNC_BFS:   state_in = start_ok ? ST_BFS_DEQ : ST_IDLE;
               endcase
            end
         end
         ST_EDGE: state_in = ST_IDLE;
         ST_DFS_SCAN: begin
            if (!cand_any) begin
               state_in = (depth_ff == CW'(1)) ? ST_IDLE : ST_DFS_POP;
            end
         end
         ST_DFS_POP: state_in = ST_DFS_SCAN;
         ST_BFS_DEQ: state_in = (head_ff == depth_ff) ? ST_IDLE : ST_BFS_ROW;
         ST_BFS_ROW: state_in = ST_BFS_SCAN;
         ST_BFS_SCAN: begin
            if (!cand_any) begin
               state_in = ST_BFS_DEQ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory commands
   always_comb begin
      visited_in    = visited_ff;
      pend_in       = pend_ff;
      depth_in      = depth_ff;
      head_in       = head_ff;
      edge_row_in   = edge_row_ff;
      edge_col_in   = edge_col_ff;
      rsp_valid_in  = 1'b0;
      rsp_vertex_in = pend_ff;
      rsp_last_in   = 1'b0;
      rsp_bad_in    = 1'b0;
      adj_cmd       = '0;
      ord_cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func) inside
                  FUNC_CLEAR: begin
                     adj_cmd.clear = 1'b1;
                  end
                  FUNC_EDGE: begin
                     if (edge_ok) begin
                        adj_cmd.wr_en  = 1'b1;
                        adj_cmd.wr_row = req_from_vertex;
                        adj_cmd.wr_col = req_to_vertex;
                        edge_row_in    = req_to_vertex;
                        edge_col_in    = req_from_vertex;
                     end
                  end
                  FUNC_DFS, FUNC_BFS: begin
                     if (!start_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_vertex_in = req_from_vertex;
                        rsp_last_in   = 1'b1;
                        rsp_bad_in    = 1'b1;
                     end else begin
                        visited_in      = MAX_VERTICES'(1) << req_from_vertex;
                        pend_in         = req_from_vertex;
                        ord_cmd.wr_en   = 1'b1;
                        ord_cmd.wr_addr = '0;
                        ord_cmd.wr_data = req_from_vertex;
                        depth_in        = CW'(1);
                        head_in         = '0;
                        if (func == FUNC_DFS) begin
                           adj_cmd.rd_en  = 1'b1;
                           adj_cmd.rd_row = req_from_vertex;
                        end
                     end
                  end
               endcase
            end
         end
         ST_EDGE: begin
            adj_cmd.wr_en  = 1'b1;
            adj_cmd.wr_row = edge_row_ff;
            adj_cmd.wr_col = edge_col_ff;
         end
         ST_DFS_SCAN: begin
            if (cand_any) begin
               rsp_valid_in    = 1'b1;
               pend_in         = next_v;
               visited_in      = visited_ff | cand_low;
               ord_cmd.wr_en   = 1'b1;
               ord_cmd.wr_addr = VERTEX_W'(depth_ff);
               ord_cmd.wr_data = next_v;
               depth_in        = depth_ff + CW'(1);
               adj_cmd.rd_en   = 1'b1;
               adj_cmd.rd_row  = next_v;
            end else if (depth_ff == CW'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               depth_in     = '0;
            end else begin
               ord_cmd.rd_en   = 1'b1;
               ord_cmd.rd_addr = VERTEX_W'(depth_ff - CW'(2));
               depth_in        = depth_ff - CW'(1);
            end
         end
         ST_DFS_POP, ST_BFS_ROW: begin
            adj_cmd.rd_en  = 1'b1;
            adj_cmd.rd_row = ord_rdata;
         end
         ST_BFS_DEQ: begin
            if (head_ff == depth_ff) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
            end else begin
               ord_cmd.rd_en   = 1'b1;
               ord_cmd.rd_addr = VERTEX_W'(head_ff);
               head_in         = head_ff + CW'(1);
            end
         end
         ST_BFS_SCAN: begin
            if (cand_any) begin
               rsp_valid_in    = 1'b1;
               pend_in         = next_v;
               visited_in      = visited_ff | cand_low;
               ord_cmd.wr_en   = 1'b1;
               ord_cmd.wr_addr = VERTEX_W'(depth_ff);
               ord_cmd.wr_data = next_v;
               depth_in        = depth_ff + CW'(1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
         head_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff     <= depth_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      visited_ff    <= visited_in;
      pend_ff       <= pend_in;
      edge_row_ff   <= edge_row_in;
      edge_col_ff   <= edge_col_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_vertex    = rsp_vertex_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_bad_start = rsp_bad_ff;

endmodule

// File: hw/rtl/graph_bfs_dfs_traversal.sv
// graph traversal over an adjacency bit matrix: an add edge sets one bit each way; a traversal
// scans the current row for each visited vertex, a dfs backtrack adds a stack read and a row read,
// and a bfs dequeue adds a queue read, a row read and a closing scan
// last result appears the cycle after the walk ends, and the next transaction is taken then
// results are one-cycle strobes on rsp_valid, the receiver cannot stall; busy covers every
// cycle in which a new transaction cannot be taken
// reset (synchronous, active high) clears the graph, the sequencer and vertex_count to 64
module graph_bfs_dfs_traversal #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // command channel
   input  logic                             start,
   output logic                             busy,
   input  logic [gbt_pkg::FUNC_W-1:0]       req_func,
   input  logic [gbt_pkg::VERTEX_W-1:0]     req_from_vertex,
   input  logic [gbt_pkg::VERTEX_W-1:0]     req_to_vertex,
   // result channel
   output logic                             rsp_valid,
   output logic [gbt_pkg::VERTEX_W-1:0]     rsp_vertex,
   output logic                             rsp_last,
   output logic                             rsp_bad_start,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gbt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [gbt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [gbt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import gbt_pkg::*;

   logic [COUNT_W-1:0]      vertex_count_ff;
   logic                    csr_wr;
   logic                    csr_hit;
   adj_cmd_type             adj_cmd;
   ord_cmd_type             ord_cmd;
   logic [MAX_VERTICES-1:0] adj_row;
   logic [VERTEX_W-1:0]     ord_rdata;

   // register file: a single word, vertex_count, at offset 0
   // the low two address bits are not decoded
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == REG_VERTEX_COUNT);
   assign csr_wr  = psel && penable && pwrite && pready;
   assign pready  = 1'b1;
   assign prdata  = csr_hit ? CSR_DATA_W'(vertex_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
      end else if (csr_wr && csr_hit) begin
         vertex_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   // sequencer: decodes each transaction, walks the graph and owns the
   // visited marks; it holds the latest vertex back one step so that the
   // final one of a run can carry the last flag
   gbt_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .vertex_count    (vertex_count_ff),
      .adj_cmd         (adj_cmd),
      .adj_row         (adj_row),
      .ord_cmd         (ord_cmd),
      .ord_rdata       (ord_rdata),
      .rsp_valid       (rsp_valid),
      .rsp_vertex      (rsp_vertex),
      .rsp_last        (rsp_last),
      .rsp_bad_start   (rsp_bad_start)
   );

   // adjacency matrix: one row per vertex; a clear only drops the row valid bits
   gbt_adj_mem #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_adj_mem (
      .clock (clock),
      .reset (reset),
      .cmd   (adj_cmd),
      .row   (adj_row)
   );

   // dfs stack or bfs queue; each entry is written before it is read
   gbt_order_mem #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_order_mem (
      .clock (clock),
      .cmd   (ord_cmd),
      .rdata (ord_rdata)
   );

endmodule

// File: hw/rtl/gbt_checker.sv
// gbt_checker: port-level checks of the graph traversal block, bound
// onto the top level; depends on gbt_pkg
module gbt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic [gbt_pkg::FUNC_W-1:0]      req_func,
   input logic                            rsp_valid,
   input logic                            rsp_last,
   input logic                            rsp_bad_start
);
   import gbt_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // a bad start is always a one-result run
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_start |-> rsp_last)
      else $error("bad start result without last flag");

   // the final result of a run leaves the block free
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("block busy while showing final result");

   // more results follow, so the walk is still going
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result while idle");

   // clear and add-edge never produce a result
   a_graph_cmd_silent: assert property (@(posedge clock) disable iff (reset)
      accept && (req_func == FUNC_CLEAR || req_func == FUNC_EDGE) |=> !rsp_valid)
      else $error("result after graph update transaction");

   // a traversal either fails at once or starts walking
   a_walk_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_func == FUNC_DFS || req_func == FUNC_BFS)
      |=> (rsp_valid && rsp_last && rsp_bad_start) || (busy && !rsp_valid))
      else $error("traversal transaction neither rejected nor started");

endmodule

bind graph_bfs_dfs_traversal gbt_checker u_gbt_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_func      (req_func),
   .rsp_valid     (rsp_valid),
   .rsp_last      (rsp_last),
   .rsp_bad_start (rsp_bad_start)
);

// File: verif/graph_bfs_dfs_traversal_tb.sv
// graph_bfs_dfs_traversal_tb: self-checking bench for the graph traversal block, with a
// scoreboard that keeps its own adjacency matrix and walks it depth- and breadth-first
// depends on gbt_pkg and graph_bfs_dfs_traversal
`timescale 1ns / 100ps

module graph_bfs_dfs_traversal_tb;
   import gbt_pkg::*;

   // idle cycles with no transaction of any kind before the run is called hung
   localparam int WATCHDOG_LIMIT = 4000;
   // quiet time after the last result: edge writes give no result but still keep the block busy
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASES         = 8;
   localparam logic [CSR_ADDR_W-1:0] COUNT_ADDR = {REG_VERTEX_COUNT, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [FUNC_W-1:0]     req_func = '0;
   logic [VERTEX_W-1:0]   req_from_vertex = '0;
   logic [VERTEX_W-1:0]   req_to_vertex = '0;
   logic                  rsp_valid;
   logic [VERTEX_W-1:0]   rsp_vertex;
   logic                  rsp_last;
   logic                  rsp_bad_start;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // scoreboard: mirrors the graph and the vertex count, and turns every accepted
   // command into the visit sequence it must produce
   class traversal_scoreboard;
      typedef struct packed {
         logic [VERTEX_W-1:0] vertex;
         logic                last;
         logic                bad_start;
      } visit_type;

      logic [ROW_MAX-1:0] adjacency [ROW_MAX];
      logic [COUNT_W-1:0] vertex_count;
      visit_type          visits_due [$];
      int                 fault_count;

      function new();
         foreach (adjacency[r]) adjacency[r] = '0;
         vertex_count = VERTEX_COUNT_RESET;
         fault_count  = 0;
      endfunction

      // counts above the matrix size behave as the full matrix
      function int vertices_in_use();
         return (vertex_count > ROW_MAX) ? ROW_MAX : int'(vertex_count);
      endfunction

      function void push_visit(int v);
         visit_type x;
         x.vertex    = VERTEX_W'(v);
         x.last      = 1'b0;
         x.bad_start = 1'b0;
         visits_due.push_back(x);
      endfunction

      // preorder walk, lowest unvisited neighbour first, explicit stack of scan points
      function void walk_depth_first(int root, int n);
         logic [ROW_MAX-1:0] seen;
         int stack_vertex [ROW_MAX];
         int next_scan [ROW_MAX];
         int depth, top, v, i, emitted;
         bit found;
         seen       = '0;
         seen[root] = 1'b1;
         push_visit(root);
         emitted         = 1;
         stack_vertex[0] = root;
         next_scan[0]    = 0;
         depth           = 1;
         while (depth > 0) begin
            top   = depth - 1;
            v     = stack_vertex[top];
            i     = next_scan[top];
            found = 1'b0;
            while (i < n && !found) begin
               if (adjacency[v][i] && !seen[i]) found = 1'b1;
               else i++;
            end
            if (found && depth < ROW_MAX && emitted < ROW_MAX) begin
               next_scan[top] = i + 1;
               seen[i]        = 1'b1;
               push_visit(i);
               emitted++;
               stack_vertex[depth] = i;
               next_scan[depth]    = 0;
               depth++;
            end else begin
               depth--;
            end
         end
      endfunction

      // fifo walk, neighbours enqueued in ascending order
      function void walk_breadth_first(int root, int n);
         logic [ROW_MAX-1:0] seen;
         int fifo [ROW_MAX];
         int head, tail, v, emitted;
         seen       = '0;
         seen[root] = 1'b1;
         fifo[0]    = root;
         head       = 0;
         tail       = 1;
         emitted    = 0;
         while (head < tail && head < ROW_MAX && emitted < ROW_MAX) begin
            v = fifo[head];
            head++;
            push_visit(v);
            emitted++;
            for (int i = 0; i < n; i++) begin
               if (adjacency[v][i] && !seen[i] && tail < ROW_MAX) begin
                  seen[i]    = 1'b1;
                  fifo[tail] = i;
                  tail++;
               end
            end
         end
      endfunction

      function void note_command(func_type func, logic [VERTEX_W-1:0] a,
                                 logic [VERTEX_W-1:0] b);
         visit_type x;
         int n;
         n = vertices_in_use();
         case (func)
            FUNC_CLEAR: begin
               foreach (adjacency[r]) adjacency[r] = '0;
            end
            FUNC_EDGE: begin
               if (a < n && b < n) begin
                  adjacency[a][b] = 1'b1;
                  adjacency[b][a] = 1'b1;
               end
            end
            default: begin
               if (a >= n) begin
                  x.vertex    = a;
                  x.last      = 1'b1;
                  x.bad_start = 1'b1;
                  visits_due.push_back(x);
               end else begin
                  if (func == FUNC_DFS) walk_depth_first(int'(a), n);
                  else walk_breadth_first(int'(a), n);
                  visits_due[visits_due.size() - 1].last = 1'b1;
               end
            end
         endcase
      endfunction

      function void check_result(logic [VERTEX_W-1:0] vertex, logic last, logic bad_start);
         visit_type want, got;
         got.vertex    = vertex;
         got.last      = last;
         got.bad_start = bad_start;
         if (visits_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, got vertex %0d last %0b bad %0b",
                     $time, vertex, last, bad_start);
            fault_count++;
         end else begin
            want = visits_due.pop_front();
            if (got !== want) begin
               $display("%0t: expected vertex %0d last %0b bad %0b, got %0d %0b %0b",
                        $time, want.vertex, want.last, want.bad_start,
                        vertex, last, bad_start);
               fault_count++;
            end
         end
      endfunction

      function void check_count(logic [CSR_DATA_W-1:0] readback);
         if (readback[COUNT_W-1:0] !== vertex_count) begin
            $display("%0t: vertex_count readback mismatch, expected %0d, got %0d",
                     $time, vertex_count, readback[COUNT_W-1:0]);
            fault_count++;
         end
      endfunction
   endclass

   traversal_scoreboard book = new();
   bit                  steady_feed = 1'b0;
   int                  idle_cycles = 0;

   graph_bfs_dfs_traversal dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_vertex      (rsp_vertex),
      .rsp_last        (rsp_last),
      .rsp_bad_start   (rsp_bad_start),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // results are one-cycle strobes; sampled at the edge that ends the cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         book.check_result(rsp_vertex, rsp_last, rsp_bad_start);
   end

   // any accepted transaction (command, result or register access) restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one command transaction; start is left high so a zero gap gives back-to-back commands
   task automatic send_command(func_type func, logic [VERTEX_W-1:0] a,
                               logic [VERTEX_W-1:0] b);
      int gap;
      gap = steady_feed ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_func        <= func;
      req_from_vertex <= a;
      req_to_vertex   <= b;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      book.note_command(func, a, b);
   endtask

   // hold the sender off until every outstanding visit has come back
   task automatic wait_for_results();
      start <= 1'b0;
      while (book.visits_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup then access phase; psel is left high so transfers can follow back to back
   task automatic apb_transfer(logic write, logic [CSR_DATA_W-1:0] data,
                               output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= COUNT_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      rdata = prdata;
   endtask

   // read the old value, write the new one with junk in the unused bits, read it back
   task automatic set_vertex_count(logic [COUNT_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      apb_transfer(1'b0, '0, readback);
      book.check_count(readback);
      apb_transfer(1'b1, {(CSR_DATA_W - COUNT_W)'($urandom()), value}, readback);
      book.vertex_count = value;
      apb_transfer(1'b0, '0, readback);
      book.check_count(readback);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // mostly in-range edges (half of them chaining a to a+1 for deep walks) and
   // traversals; a little clearing and a tail of fully random noise
   task automatic random_command(int n);
      int pick, a, b;
      func_type func;
      pick = $urandom_range(0, 99);
      a    = $urandom_range(0, 63);
      b    = $urandom_range(0, 63);
      if (n > 0 && pick < 90) begin
         a = $urandom_range(0, n - 1);
         b = ($urandom_range(0, 1) == 0) ? (a + 1) % n : $urandom_range(0, n - 1);
      end
      if (pick < 45) func = FUNC_EDGE;
      else if (pick < 80) func = ($urandom_range(0, 1) == 0) ? FUNC_DFS : FUNC_BFS;
      else if (pick < 85) func = FUNC_CLEAR;
      else func = func_type'(FUNC_W'($urandom_range(0, 3)));
      send_command(func, VERTEX_W'(a), VERTEX_W'(b));
   endtask

   initial begin
      logic [COUNT_W-1:0] phase_count [PHASES];
      int n, items;
      phase_count = '{7'd1, 7'd127, 7'd0, 7'd2, 7'd64, 7'd100, 7'd64, 7'd64};
      // two phases with a mid-range count drawn fresh each run
      phase_count[4] = COUNT_W'($urandom_range(3, 63));
      phase_count[6] = COUNT_W'($urandom_range(3, 64));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full matrix: walks over an empty graph, then a small graph touching the
      // extreme vertices, alternating bit patterns and a self loop
      set_vertex_count(7'd64);
      send_command(FUNC_DFS, 6'd0, 6'd0);
      send_command(FUNC_BFS, 6'd63, 6'd63);
      send_command(FUNC_EDGE, 6'd0, 6'd63);
      send_command(FUNC_EDGE, 6'd63, 6'd62);
      send_command(FUNC_EDGE, 6'd5, 6'd5);
      send_command(FUNC_EDGE, 6'd0, 6'd1);
      send_command(FUNC_EDGE, 6'd1, 6'd42);
      send_command(FUNC_EDGE, 6'd21, 6'd0);
      send_command(FUNC_EDGE, 6'd0, 6'd40);
      send_command(FUNC_DFS, 6'd0, 6'd21);
      send_command(FUNC_BFS, 6'd0, 6'd42);
      send_command(FUNC_DFS, 6'd63, 6'd0);
      send_command(FUNC_BFS, 6'd5, 6'd0);

      // shrunk count: stored edges above it must not be followed, out-of-range
      // edges are dropped and out-of-range starts are flagged
      wait_for_results();
      set_vertex_count(7'd8);
      send_command(FUNC_DFS, 6'd0, 6'd0);
      send_command(FUNC_EDGE, 6'd3, 6'd9);
      send_command(FUNC_EDGE, 6'd7, 6'd2);
      send_command(FUNC_BFS, 6'd2, 6'd0);
      send_command(FUNC_DFS, 6'd9, 6'd0);
      send_command(FUNC_BFS, 6'd63, 6'd63);

      // zero count: nothing is in range
      wait_for_results();
      set_vertex_count(7'd0);
      send_command(FUNC_DFS, 6'd0, 6'd0);
      send_command(FUNC_EDGE, 6'd0, 6'd0);
      send_command(FUNC_BFS, 6'd0, 6'd0);

      // count beyond the matrix: the old edges come back into view, then the clear
      wait_for_results();
      set_vertex_count(7'd127);
      send_command(FUNC_BFS, 6'd40, 6'd0);
      send_command(FUNC_CLEAR, 6'd0, 6'd0);
      send_command(FUNC_DFS, 6'd40, 6'd0);

      // random phases, each under its own count; bursts with no gaps come and go
      for (int p = 0; p < PHASES; p++) begin
         wait_for_results();
         set_vertex_count(phase_count[p]);
         n     = book.vertices_in_use();
         items = (n <= 2) ? 20 : 50;
         if ($urandom_range(0, 1) == 0) send_command(FUNC_CLEAR, 6'd0, 6'd0);
         for (int k = 0; k < items; k++) begin
            if (k % 16 == 0) steady_feed = ($urandom_range(0, 2) == 0);
            if (k == items / 2) wait_for_results();
            random_command(n);
         end
      end

      wait_for_results();
      if (book.fault_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
